@@ rtl/sacm_pkg.sv @@
// Package of the set-associative LRU cache tag and miss controller.
// Holds the channel word types, status codes and front-to-back link types.
// Depends on nothing; every other file but sacm_ram imports it.
`timescale 1ns / 1ps
`default_nettype none
package sacm_pkg;

  localparam int ADDR_W = 48;

  typedef enum logic [2:0] {
    ST_HIT        = 3'd0,
    ST_MERGED     = 3'd1,
    ST_ISSUED     = 3'd2,
    ST_MSHR_FULL  = 3'd3,
    ST_SET_LOCKED = 3'd4,
    ST_FILL_DONE  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    K_READ  = 2'd0,
    K_WRITE = 2'd1,
    K_FILL  = 2'd2
  } kind_t;

  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FILL  = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] access_address;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              mem_read_valid;
    logic [ADDR_W-1:0] mem_read_address;
    logic              writeback_valid;
    logic [ADDR_W-1:0] writeback_address;
  } out_word_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] addr;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } fq_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_t;

endpackage
`default_nettype wire

@@ rtl/sacm_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module sacm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/sacm_front.sv @@
// Front end: accepts input words, masks the address, classifies the opcode
// and holds them in a two-entry queue for the back end. Uses sacm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sacm_front
  import sacm_pkg::*;
#(
  parameter int ADDRESS_BITS = 48
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_word,
  output fq_t           fq,
  input  wire bk_t      bk
);

  localparam logic [ADDR_W-1:0] AMASK = (ADDRESS_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
                                        ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);

  q_entry_t   q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  q_entry_t   ent;

  assign in_stall = bk.clearing | (cnt_r == 2'd2);
  assign push     = in_valid & ~in_stall;

  always_comb begin
    case (in_word.opcode)
      OP_WRITE: ent.kind = K_WRITE;
      OP_FILL:  ent.kind = K_FILL;
      default:  ent.kind = K_READ;
    endcase
    ent.addr = in_word.access_address & AMASK;
  end

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, bk.pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (bk.pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= ent;
    end
  end

  assign fq.valid = (cnt_r != 2'd0);
  assign fq.entry = q_r[rp_r];

endmodule
`default_nettype wire

@@ rtl/sacm_back.sv @@
// Back end: set RAM, miss-status entries and the read/update sequencer
// that resolves each queued word into one result word. Uses sacm_pkg, sacm_ram.
`timescale 1ns / 1ps
`default_nettype none
module sacm_back
  import sacm_pkg::*;
#(
  parameter int WAYS         = 8,
  parameter int SETS         = 1024,
  parameter int BLOCK_BYTES  = 64,
  parameter int MISS_ENTRIES = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire fq_t  fq,
  output bk_t       bk,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_word_t out_word
);

  localparam int OFF_W    = $clog2(BLOCK_BYTES);
  localparam int BLK_W    = ADDR_W - OFF_W;
  localparam int SET_BITS = $clog2(SETS);
  localparam int SI_W     = (SETS > 1) ? SET_BITS : 1;
  localparam int TAG_W    = BLK_W - SET_BITS;
  localparam int RW       = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int EW       = (MISS_ENTRIES > 1) ? $clog2(MISS_ENTRIES) : 1;
  localparam int LW       = 3 + RW + TAG_W;
  localparam int ROW_W    = WAYS * LW;

  typedef enum logic [2:0] {
    S_CLEAR  = 3'b001,
    S_READ   = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [SI_W-1:0] clr_r, clr_nxt;

  logic             mv_r  [MISS_ENTRIES];
  logic [BLK_W-1:0] mblk_r[MISS_ENTRIES];
  logic [RW-1:0]    mway_r[MISS_ENTRIES];

  out_word_t ow_r, ow_nxt;
  logic      ov_r, ov_nxt;

  logic [BLK_W-1:0] blk;
  logic [SI_W-1:0]  set_idx;
  logic [TAG_W-1:0] tag;
  logic [ROW_W-1:0] rrow, wrow;
  logic             we;
  logic [SI_W-1:0]  waddr;
  logic             fire;

  // Per-way views of the row, old and new.
  logic             v [WAYS], d [WAYS], lk [WAYS];
  logic [RW-1:0]    rk [WAYS];
  logic [TAG_W-1:0] tg [WAYS];
  logic             nv [WAYS], nd [WAYS], nlk [WAYS];
  logic [RW-1:0]    nrk [WAYS];
  logic [TAG_W-1:0] ntg [WAYS];

  logic          hit_any, m_hit, f_any, inv_any, vic_any;
  logic [RW-1:0] hit_way, inv_way, vic_way, best, alloc_way, rec_way;
  logic [EW-1:0] m_idx, f_idx;
  logic          do_recent, do_alloc, do_fill;
  logic [RW:0]   rlim;
  logic [BLK_W-1:0] vblk;

  assign blk     = fq.entry.addr[ADDR_W-1:OFF_W];
  assign set_idx = (SETS > 1) ? SI_W'(blk) : '0;
  assign tag     = TAG_W'(blk >> SET_BITS);

  sacm_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wrow),
    .raddr (set_idx),
    .rdata (rrow)
  );

  assign fire = (state_r == S_UPDATE) & (~ov_r | ~out_stall);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == SI_W'(SETS - 1)) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (fq.valid) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (fire) begin
          state_nxt = S_READ;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Resolve the head word against the set row and the miss entries.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      tg[w] = rrow[w*LW +: TAG_W];
      rk[w] = rrow[w*LW + TAG_W +: RW];
      lk[w] = rrow[w*LW + TAG_W + RW];
      d[w]  = rrow[w*LW + TAG_W + RW + 1];
      v[w]  = rrow[w*LW + TAG_W + RW + 2];
    end

    hit_any = 1'b0; hit_way = '0;
    inv_any = 1'b0; inv_way = '0;
    vic_any = 1'b0; vic_way = '0; best = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_any && v[w] && tg[w] == tag && !lk[w]) begin
        hit_any = 1'b1; hit_way = RW'(w);
      end
      if (!inv_any && !v[w]) begin
        inv_any = 1'b1; inv_way = RW'(w);
      end
      if (!lk[w] && (!vic_any || rk[w] > best)) begin
        vic_any = 1'b1; vic_way = RW'(w); best = rk[w];
      end
    end

    m_hit = 1'b0; m_idx = '0;
    f_any = 1'b0; f_idx = '0;
    for (int e = 0; e < MISS_ENTRIES; e++) begin
      if (!m_hit && mv_r[e] && mblk_r[e] == blk) begin
        m_hit = 1'b1; m_idx = EW'(e);
      end
      if (!f_any && !mv_r[e]) begin
        f_any = 1'b1; f_idx = EW'(e);
      end
    end

    alloc_way = inv_any ? inv_way : vic_way;
    vblk      = (BLK_W'(tg[vic_way]) << SET_BITS) | BLK_W'(set_idx);

    ow_nxt    = '0;
    do_recent = 1'b0;
    do_alloc  = 1'b0;
    do_fill   = 1'b0;
    rec_way   = hit_way;
    for (int w = 0; w < WAYS; w++) begin
      nv[w] = v[w]; nd[w] = d[w]; nlk[w] = lk[w]; ntg[w] = tg[w];
    end

    case (fq.entry.kind)
      K_FILL: begin
        ow_nxt.status = ST_FILL_DONE;
        if (m_hit) begin
          do_fill = 1'b1;
          nlk[mway_r[m_idx]] = 1'b0;
        end
      end
      default: begin
        if (hit_any) begin
          ow_nxt.status = ST_HIT;
          do_recent     = 1'b1;
          if (fq.entry.kind == K_WRITE) begin
            nd[hit_way] = 1'b1;
          end
        end else if (m_hit) begin
          ow_nxt.status = ST_MERGED;
          if (fq.entry.kind == K_WRITE) begin
            nd[mway_r[m_idx]] = 1'b1;
          end
        end else if (!f_any) begin
          ow_nxt.status = ST_MSHR_FULL;
        end else if (!inv_any && !vic_any) begin
          ow_nxt.status = ST_SET_LOCKED;
        end else begin
          ow_nxt.status           = ST_ISSUED;
          do_recent               = 1'b1;
          do_alloc                = 1'b1;
          rec_way                 = alloc_way;
          ow_nxt.mem_read_valid   = 1'b1;
          ow_nxt.mem_read_address = {blk, {OFF_W{1'b0}}};
          if (!inv_any && d[vic_way]) begin
            ow_nxt.writeback_valid   = 1'b1;
            ow_nxt.writeback_address = {vblk, {OFF_W{1'b0}}};
          end
          nv[alloc_way]  = 1'b1;
          ntg[alloc_way] = tag;
          nd[alloc_way]  = (fq.entry.kind == K_WRITE);
          nlk[alloc_way] = 1'b1;
        end
      end
    endcase

    // Move the touched way to the front of the recency order.
    rlim = v[rec_way] ? {1'b0, rk[rec_way]} : (RW+1)'(WAYS);
    for (int w = 0; w < WAYS; w++) begin
      nrk[w] = rk[w];
      if (do_recent) begin
        if (RW'(w) == rec_way) begin
          nrk[w] = '0;
        end else if (v[w] && {1'b0, rk[w]} < rlim) begin
          nrk[w] = rk[w] + 1'b1;
        end
      end
    end

    for (int w = 0; w < WAYS; w++) begin
      wrow[w*LW +: LW] = {nv[w], nd[w], nlk[w], nrk[w], ntg[w]};
    end

    if (state_r == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_r;
      wrow  = '0;
    end else begin
      we    = fire;
      waddr = set_idx;
    end

    ov_nxt = fire ? 1'b1 : (ov_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
      for (int e = 0; e < MISS_ENTRIES; e++) begin
        mv_r[e] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
      if (fire && do_fill) begin
        mv_r[m_idx] <= 1'b0;
      end
      if (fire && do_alloc) begin
        mv_r[f_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ow_r <= ow_nxt;
      if (do_alloc) begin
        mblk_r[f_idx] <= blk;
        mway_r[f_idx] <= alloc_way;
      end
    end
  end

  assign bk.pop      = fire;
  assign bk.clearing = (state_r == S_CLEAR);
  assign out_valid   = ov_r;
  assign out_word    = ow_r;

endmodule
`default_nettype wire

@@ rtl/set_assoc_lru_cache_mshr_unit.sv @@
// Top level of the set-associative LRU cache tag and miss controller.
// Depends on sacm_pkg, sacm_front, sacm_back (which holds sacm_ram).
`timescale 1ns / 1ps
`default_nettype none
// Every accepted word (read, write or fill return) yields exactly one result
// word, in order. After reset the block clears the set RAM, one set per cycle,
// and holds in_stall high during that pass. From then on the back end takes
// one word at a time: in S_READ it reads the word's set row from the set RAM,
// and in S_UPDATE it compares tags, picks a victim, updates the LRU ranks and
// writes the row back, waiting there while a stalled result is still held.
// A two-entry queue in front and a result register at the back let both
// channels stall independently. SETS and BLOCK_BYTES are expected to be
// powers of two. The miss-status entries live in flip-flops, so a fill
// return or a merge is resolved in the same update cycle as a tag lookup.
module set_assoc_lru_cache_mshr_unit
  import sacm_pkg::*;
#(
  parameter int WAYS         = 8,
  parameter int SETS         = 1024,
  parameter int BLOCK_BYTES  = 64,
  parameter int MISS_ENTRIES = 16,
  parameter int ADDRESS_BITS = 48
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_word,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_word_t     out_word
);

  fq_t fq;
  bk_t bk;

  // The front end decodes and queues words.
  sacm_front #(.ADDRESS_BITS(ADDRESS_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .fq       (fq),
    .bk       (bk)
  );

  // The back end owns all cache and miss state.
  sacm_back #(
    .WAYS         (WAYS),
    .SETS         (SETS),
    .BLOCK_BYTES  (BLOCK_BYTES),
    .MISS_ENTRIES (MISS_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fq        (fq),
    .bk        (bk),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

@@ rtl/sacm_checker.sv @@
// Port-level checker of the cache controller and its bind to the top level.
// Depends on sacm_pkg and set_assoc_lru_cache_mshr_unit.
`timescale 1ns / 1ps
`default_nettype none
module sacm_checker
  import sacm_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_word
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  a_rd_only_issue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status != ST_ISSUED |->
      !out_word.mem_read_valid && out_word.mem_read_address == '0)
    else $error("memory read outside a miss issue");

  a_wb_needs_rd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.writeback_valid || out_word.writeback_address != '0) |->
      out_word.mem_read_valid)
    else $error("writeback without a miss issue");

  a_issue_rd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == ST_ISSUED |-> out_word.mem_read_valid)
    else $error("miss issued without memory read");

endmodule

bind set_assoc_lru_cache_mshr_unit sacm_checker u_sacm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
`default_nettype wire

@@ test/testbench.sv @@
// Testbench of the set-associative LRU cache tag and miss controller.
// Checks each result word against a behavioral copy of the tag, LRU and miss state.
// Depends on sacm_pkg and set_assoc_lru_cache_mshr_unit.
`timescale 1ns / 1ps
module testbench;
  import sacm_pkg::*;

  localparam int WAYS = 8;
  localparam int SETS = 1024;
  localparam int BLOCK_BYTES = 64;
  localparam int MISS_ENTRIES = 16;
  localparam int LINES = WAYS * SETS;
  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;

  set_assoc_lru_cache_mshr_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted cache state.
  bit        lv[LINES];
  bit [31:0] ltag[LINES];
  bit        ldirty[LINES];
  bit        llock[LINES];
  bit [3:0]  lrank[LINES];
  bit        mv[MISS_ENTRIES];
  bit [41:0] mblk[MISS_ENTRIES];
  int        mslot[MISS_ENTRIES];

  out_word_t expected_words[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  // Addresses seen recently, so random accesses revisit hot blocks.
  logic [47:0] recent_addr[$];

  task automatic promote(int base, int way);
    int r;
    r = lv[base + way] ? lrank[base + way] : WAYS;
    for (int w = 0; w < WAYS; w++)
      if (w != way && lv[base + w] && lrank[base + w] < r) lrank[base + w]++;
    lrank[base + way] = 0;
  endtask

  task automatic predict_word(in_word_t iw);
    out_word_t o;
    logic [41:0] blk;
    int set_idx, base, free_e, way, best;
    bit done;
    logic [31:0] tg;
    o = '0;
    blk = iw.access_address[47:6];
    set_idx = int'(blk % SETS);
    tg = 32'(blk / SETS);
    base = set_idx * WAYS;
    done = 0;
    if (iw.opcode == OP_FILL) begin
      for (int e = 0; e < MISS_ENTRIES; e++)
        if (mv[e] && mblk[e] == blk) begin
          llock[mslot[e]] = 0;
          mv[e] = 0;
          break;
        end
      o.status = ST_FILL_DONE;
    end else begin
      for (int w = 0; w < WAYS && !done; w++)
        if (lv[base + w] && ltag[base + w] == tg && !llock[base + w]) begin
          if (iw.opcode == OP_WRITE) ldirty[base + w] = 1;
          promote(base, w);
          o.status = ST_HIT;
          done = 1;
        end
      for (int e = 0; e < MISS_ENTRIES && !done; e++)
        if (mv[e] && mblk[e] == blk) begin
          if (iw.opcode == OP_WRITE) ldirty[mslot[e]] = 1;
          o.status = ST_MERGED;
          done = 1;
        end
      if (!done) begin
        free_e = MISS_ENTRIES;
        for (int e = 0; e < MISS_ENTRIES; e++)
          if (!mv[e] && free_e == MISS_ENTRIES) free_e = e;
        if (free_e == MISS_ENTRIES) begin
          o.status = ST_MSHR_FULL;
        end else begin
          way = WAYS;
          best = 0;
          for (int w = 0; w < WAYS; w++)
            if (!lv[base + w]) begin
              way = w;
              break;
            end
          if (way == WAYS) begin
            for (int w = 0; w < WAYS; w++)
              if (!llock[base + w] && (way == WAYS || lrank[base + w] > best)) begin
                way = w;
                best = lrank[base + w];
              end
            if (way != WAYS && ldirty[base + way]) begin
              o.writeback_valid = 1'b1;
              o.writeback_address = {ltag[base + way], 10'(set_idx), 6'd0};
            end
          end
          if (way == WAYS) begin
            o = '0;
            o.status = ST_SET_LOCKED;
          end else begin
            promote(base, way);
            lv[base + way] = 1;
            ltag[base + way] = tg;
            ldirty[base + way] = (iw.opcode == OP_WRITE);
            llock[base + way] = 1;
            mv[free_e] = 1;
            mblk[free_e] = blk;
            mslot[free_e] = base + way;
            o.mem_read_valid = 1'b1;
            o.mem_read_address = {blk, 6'd0};
            o.status = ST_ISSUED;
          end
        end
      end
    end
    expected_words = {expected_words, o};
  endtask

  // Send one word; the prediction is made when the block accepts it.
  // Valid stays high after acceptance so that the next word can follow at once.
  task automatic send_word(logic [1:0] op, logic [47:0] addr);
    in_word_t iw;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    iw.opcode = op;
    iw.access_address = addr;
    in_valid <= 1'b1;
    in_word <= iw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(iw);
    if (recent_addr.size() > 40) void'(recent_addr.pop_front());
    recent_addr = {recent_addr, addr};
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Address in a chosen set with a chosen tag, to pile lines into a set.
  function automatic logic [47:0] set_addr(int set_idx, int tg);
    return {32'(tg), 10'(set_idx), 6'($urandom)};
  endfunction

  task automatic test_directed();
    send_word(K_READ, 48'h0);
    send_word(K_READ, 48'h0);
    send_word(K_FILL, 48'h0);
    send_word(K_WRITE, 48'h3f);
    send_word(K_READ, 48'hffff_ffff_ffff);
    send_word(K_WRITE, 48'hffff_ffff_ffc0);
    send_word(K_FILL, 48'hffff_ffff_ffff);
    send_word(K_FILL, 48'h1234_5678_9ac0);
    send_word(2'd3, 48'h5555_5555_5555);
    send_word(2'd3, 48'haaaa_aaaa_aaaa);
    // Fill one set with eight dirty lines, find it locked, fill them in, then evict one with a writeback.
    for (int t = 1; t <= 8; t++) send_word(K_WRITE, set_addr(7, t));
    send_word(K_READ, set_addr(7, 9));
    for (int t = 1; t <= 8; t++) send_word(K_FILL, set_addr(7, t));
    send_word(K_READ, set_addr(7, 9));
    drain_results();
  endtask

  // Lock every line of a set and overrun the miss entries.
  task automatic test_stalls();
    for (int t = 0; t < 8; t++) send_word(K_READ, set_addr(3, 100 + t));
    send_word(K_WRITE, set_addr(3, 200));
    for (int s = 0; s < 10; s++) send_word(K_READ, set_addr(500 + s, 1));
    send_word(K_WRITE, set_addr(3, 100));
    for (int t = 0; t < 8; t++) send_word(K_FILL, set_addr(3, 100 + t));
    for (int s = 0; s < 10; s++) send_word(K_FILL, set_addr(500 + s, 1));
    drain_results();
  endtask

  task automatic test_random(int count);
    logic [1:0] op;
    logic [47:0] addr;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(99) < 30) ? K_FILL : 2'($urandom_range(1));
      if ($urandom_range(99) < 3) op = 2'd3;
      case ($urandom_range(9))
        0: addr = 48'({$urandom, $urandom});
        1, 2, 3: addr = recent_addr.size() ? recent_addr[$urandom_range(recent_addr.size() - 1)]
                                           : 48'h0;
        default: addr = set_addr($urandom_range(3), $urandom_range(15));
      endcase
      send_word(op, addr);
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 200;
    for (int i = 0; i < 30; i++) send_word(2'($urandom_range(1)), set_addr(9, i % 12));
    drain_results();
    for (int i = 0; i < 12; i++) send_word(K_FILL, set_addr(9, i));
    drain_results();
  endtask

  // Receiver stall generator, with an optional long hold-off.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: %h", out_word);
        errors++;
      end else begin
        exp_w = expected_words.pop_front();
        if (out_word.status !== exp_w.status) begin
          $error("status expected %0d actual %0d", exp_w.status, out_word.status);
          errors++;
        end
        if (out_word.mem_read_valid !== exp_w.mem_read_valid) begin
          $error("mem_read_valid expected %0d actual %0d",
                 exp_w.mem_read_valid, out_word.mem_read_valid);
          errors++;
        end
        if (out_word.mem_read_address !== exp_w.mem_read_address) begin
          $error("mem_read_address expected %h actual %h",
                 exp_w.mem_read_address, out_word.mem_read_address);
          errors++;
        end
        if (out_word.writeback_valid !== exp_w.writeback_valid) begin
          $error("writeback_valid expected %0d actual %0d",
                 exp_w.writeback_valid, out_word.writeback_valid);
          errors++;
        end
        if (out_word.writeback_address !== exp_w.writeback_address) begin
          $error("writeback_address expected %h actual %h",
                 exp_w.writeback_address, out_word.writeback_address);
          errors++;
        end
      end
    end
  end

  // Watchdog; the clearing pass after reset is small next to the limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_stalls();
    send_idle_pct = 7;
    recv_idle_pct = 67;
    test_random(550);
    send_idle_pct = 67;
    recv_idle_pct = 7;
    test_random(550);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(550);
    drain_results();
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sacm_pkg.sv
rtl/sacm_ram.sv
rtl/sacm_front.sv
rtl/sacm_back.sv
rtl/set_assoc_lru_cache_mshr_unit.sv
rtl/sacm_checker.sv
test/testbench.sv
